@@ sv/prcs_pkg.sv @@
// ----------------------------------------------------------------------------
// prcs_pkg
// Shared types and constants for the priority command scheduler.
// ----------------------------------------------------------------------------
package prcs_pkg;

  localparam int QueueDepth    = 16;
  localparam int NumIds        = 16;
  localparam int MaxSubsystems = 16;
  localparam int PriorityBits  = 8;

  localparam int QIdxW  = $clog2(QueueDepth);
  localparam int QCntW  = $clog2(QueueDepth + 1);
  localparam int IdW    = 4;
  localparam int SubCntW = $clog2(MaxSubsystems + 1);

  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_ADD    = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;
  localparam logic [1:0] CMD_CLEAR  = 2'd3;

  localparam logic [1:0] ST_IDLE        = 2'd0;
  localparam logic [1:0] ST_RUNNING     = 2'd1;
  localparam logic [1:0] ST_FINISHED    = 2'd2;
  localparam logic [1:0] ST_INTERRUPTED = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_ADD,
    S_REMOVE,
    S_WALK,
    S_PACK
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic latch;       // capture the input item
    logic clear;       // empty the queue
    logic search_init; // start a scan over the queue
    logic search_step; // advance the scan one entry
    logic add_step;    // shift one entry / insert
    logic rem_step;    // shift one entry down
    logic walk_init;   // begin a tick walk
    logic walk_step;   // offer one entry for grant and report it
    logic pack_step;   // move one surviving entry down over dropped ones
  } ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic cmd_tick;
    logic cmd_add;
    logic cmd_remove;
    logic id_ok;
    logic search_done;
    logic found;
    logic full;
    logic add_done;
    logic rem_done;
    logic walk_empty;
    logic walk_done;
    logic pack_done;
  } stat_t;

endpackage

@@ sv/prcs_datapath.sv @@
// ----------------------------------------------------------------------------
// prcs_datapath
// Queue storage, run status, scan pointers and grant logic.
// ----------------------------------------------------------------------------
module prcs_datapath (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  prcs_pkg::ctrl_t                      ctrl,
  output prcs_pkg::stat_t                      stat,
  input  logic                                 rem_load,
  input  logic [1:0]                           in_cmd,
  input  logic [3:0]                           in_command_id,
  input  logic [7:0]                           in_priority_req,
  input  logic [15:0]                          in_requirement_mask,
  input  logic [15:0]                          in_can_run_mask,
  input  logic [15:0]                          in_finished_mask,
  input  logic                                 cfg_we,
  input  logic [4:0]                           cfg_wdata,
  output logic                                 out_valid,
  output logic [3:0]                           out_result_id,
  output logic                                 out_started,
  output logic                                 out_executed,
  output logic                                 out_ended,
  output logic                                 out_was_interrupted,
  output logic                                 out_dropped,
  output logic                                 out_last
);

  localparam int QW = prcs_pkg::QIdxW;
  localparam int CW = prcs_pkg::QCntW;
  localparam int PW = prcs_pkg::PriorityBits;
  localparam int MW = prcs_pkg::MaxSubsystems;

  logic [3:0]    qid_r   [prcs_pkg::QueueDepth];
  logic [PW-1:0] qprio_r [prcs_pkg::QueueDepth];
  logic [MW-1:0] qmask_r [prcs_pkg::QueueDepth];
  logic [1:0]    run_r   [prcs_pkg::NumIds];
  logic [prcs_pkg::QueueDepth-1:0] drop_r;

  logic [CW-1:0] count_r;
  logic [MW-1:0] claimed_r;
  logic [prcs_pkg::SubCntW-1:0] nclaim_r;
  logic [4:0]    nsub_r;

  logic [1:0]    cmd_r;
  logic [3:0]    id_r;
  logic [PW-1:0] prio_r;
  logic [MW-1:0] req_r;
  logic [15:0]   can_r, fin_r;

  // scan pointer: search position, then insert/remove shift position and pack read position
  logic [CW-1:0] ptr_r;
  logic          found_r;
  logic [CW-1:0] pos_r;  // first entry with greater priority (add) or match
  logic [CW-1:0] k_r;    // walk: entries left

  logic [QW-1:0] pi;
  logic [QW-1:0] wi;
  logic [QW-1:0] wr;
  logic          granted;
  logic          dr;
  logic [3:0]    eid;
  logic          canb, finb;

  assign pi = ptr_r[QW-1:0];
  assign wr = pos_r[QW-1:0];
  assign wi = QW'(k_r - CW'(1));
  assign eid = qid_r[wi];
  assign canb = can_r[eid];
  assign finb = fin_r[eid];
  assign granted = canb && ({1'b0, nclaim_r} != {1'b0, nsub_r}) &&
                   ((qmask_r[wi] & claimed_r) == '0);
  assign dr = (granted ? finb : 1'b1) && (qprio_r[wi] != '0);

  always_comb begin
    stat.cmd_tick    = (cmd_r == prcs_pkg::CMD_TICK);
    stat.cmd_add     = (cmd_r == prcs_pkg::CMD_ADD);
    stat.cmd_remove  = (cmd_r == prcs_pkg::CMD_REMOVE);
    stat.id_ok       = 1'b1;
    stat.search_done = (ptr_r == count_r);
    stat.found       = found_r;
    stat.full        = (count_r == CW'(prcs_pkg::QueueDepth));
    stat.add_done    = (ptr_r == pos_r);
    stat.rem_done    = (ptr_r + CW'(1) >= count_r);
    stat.walk_empty  = (count_r == '0);
    stat.walk_done   = (k_r == CW'(1));
    stat.pack_done   = (ptr_r + CW'(1) >= count_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nsub_r  <= 5'd16;
      count_r <= '0;
      claimed_r <= '0;
      nclaim_r <= '0;
      out_valid <= 1'b0;
      for (int j = 0; j < prcs_pkg::NumIds; j++) run_r[j] <= prcs_pkg::ST_IDLE;
    end else begin
      out_valid <= 1'b0;
      if (cfg_we) nsub_r <= cfg_wdata;
      if (ctrl.clear) count_r <= '0;
      if (ctrl.walk_init) begin
        claimed_r <= '0;
        nclaim_r  <= '0;
      end
      if (ctrl.add_step && ptr_r == pos_r) count_r <= count_r + CW'(1);
      if (ctrl.rem_step && ptr_r + CW'(1) >= count_r) count_r <= count_r - CW'(1);
      if (ctrl.walk_step) begin
        out_valid <= 1'b1;
        if (granted) begin
          claimed_r <= claimed_r | qmask_r[wi];
          nclaim_r  <= prcs_pkg::SubCntW'($countones(claimed_r | qmask_r[wi]));
          run_r[eid] <= finb ? prcs_pkg::ST_FINISHED : prcs_pkg::ST_RUNNING;
        end else if (run_r[eid] == prcs_pkg::ST_RUNNING) begin
          run_r[eid] <= prcs_pkg::ST_INTERRUPTED;
        end
      end
      // survivors counted by the write pointer after the last entry
      if (ctrl.pack_step && ptr_r + CW'(1) >= count_r)
        count_r <= drop_r[pi] ? pos_r : pos_r + CW'(1);
    end
  end

  // payload and scan registers
  always_ff @(posedge clk) begin
    if (ctrl.latch) begin
      cmd_r  <= in_cmd;
      id_r   <= in_command_id;
      prio_r <= in_priority_req;
      req_r  <= in_requirement_mask;
      can_r  <= in_can_run_mask;
      fin_r  <= in_finished_mask;
    end
    if (ctrl.search_init) begin
      ptr_r   <= '0;
      found_r <= 1'b0;
      pos_r   <= count_r;
    end
    if (ctrl.search_step) begin
      if (!found_r && qid_r[pi] == id_r) begin
        found_r <= 1'b1;
        if (cmd_r == prcs_pkg::CMD_REMOVE) pos_r <= ptr_r;
      end
      if (cmd_r == prcs_pkg::CMD_ADD && pos_r == count_r && prio_r < qprio_r[pi])
        pos_r <= ptr_r;
      ptr_r <= ptr_r + CW'(1);
    end
    // remove shifts from the matching slot
    if (rem_load) ptr_r <= pos_r;
    if (ctrl.add_step) begin
      // shift up from the tail, then insert at pos
      if (ptr_r == pos_r) begin
        qid_r[pi]   <= id_r;
        qprio_r[pi] <= prio_r;
        qmask_r[pi] <= req_r;
      end else begin
        qid_r[pi]   <= qid_r[QW'(ptr_r - CW'(1))];
        qprio_r[pi] <= qprio_r[QW'(ptr_r - CW'(1))];
        qmask_r[pi] <= qmask_r[QW'(ptr_r - CW'(1))];
        ptr_r <= ptr_r - CW'(1);
      end
    end
    if (ctrl.rem_step) begin
      if (ptr_r + CW'(1) < count_r) begin
        qid_r[pi]   <= qid_r[QW'(ptr_r + CW'(1))];
        qprio_r[pi] <= qprio_r[QW'(ptr_r + CW'(1))];
        qmask_r[pi] <= qmask_r[QW'(ptr_r + CW'(1))];
        ptr_r <= ptr_r + CW'(1);
      end
    end
    if (ctrl.walk_init) begin
      k_r   <= count_r;
      ptr_r <= '0;
      pos_r <= '0;
    end
    if (ctrl.walk_step) begin
      // mark drops here; the pack pass closes the gaps afterwards
      drop_r[wi] <= dr;
      k_r <= k_r - CW'(1);
      out_result_id       <= eid;
      out_started         <= granted && (run_r[eid] != prcs_pkg::ST_RUNNING);
      out_executed        <= granted;
      out_ended           <= granted && finb;
      out_was_interrupted <= !granted && (run_r[eid] == prcs_pkg::ST_RUNNING);
      out_dropped         <= dr;
      out_last            <= (k_r == CW'(1));
    end
    if (ctrl.pack_step) begin
      // read pointer never trails the write pointer, so copy in place
      if (!drop_r[pi]) begin
        qid_r[wr]   <= qid_r[pi];
        qprio_r[wr] <= qprio_r[pi];
        qmask_r[wr] <= qmask_r[pi];
        pos_r <= pos_r + CW'(1);
      end
      ptr_r <= ptr_r + CW'(1);
    end
  end

endmodule

@@ sv/prcs_ctrl.sv @@
// ----------------------------------------------------------------------------
// prcs_ctrl
// Sequencer: scan for add/remove, shift the queue, walk and pack on tick, empty on clear.
// ----------------------------------------------------------------------------
module prcs_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  prcs_pkg::stat_t stat,
  output prcs_pkg::ctrl_t ctrl,
  output logic            rem_load
);

  prcs_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= prcs_pkg::S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      prcs_pkg::S_IDLE: if (start) state_nxt = prcs_pkg::S_SEARCH;
      prcs_pkg::S_SEARCH: begin
        priority if (stat.cmd_tick) begin
          state_nxt = stat.walk_empty ? prcs_pkg::S_IDLE : prcs_pkg::S_WALK;
        end else if (!stat.cmd_add && !stat.cmd_remove) begin
          state_nxt = prcs_pkg::S_IDLE;
        end else if (stat.search_done) begin
          if (stat.cmd_add)
            state_nxt = (stat.found || stat.full) ? prcs_pkg::S_IDLE : prcs_pkg::S_ADD;
          else
            state_nxt = stat.found ? prcs_pkg::S_REMOVE : prcs_pkg::S_IDLE;
        end
      end
      prcs_pkg::S_ADD:    if (stat.add_done) state_nxt = prcs_pkg::S_IDLE;
      prcs_pkg::S_REMOVE: if (stat.rem_done) state_nxt = prcs_pkg::S_IDLE;
      prcs_pkg::S_WALK:   if (stat.walk_done) state_nxt = prcs_pkg::S_PACK;
      prcs_pkg::S_PACK:   if (stat.pack_done) state_nxt = prcs_pkg::S_IDLE;
      default: state_nxt = prcs_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    busy = (state_r != prcs_pkg::S_IDLE);
    rem_load = 1'b0;
    unique case (state_r)
      prcs_pkg::S_IDLE: begin
        ctrl.latch       = start;
        ctrl.search_init = start;
      end
      prcs_pkg::S_SEARCH: begin
        priority if (stat.cmd_tick) begin
          ctrl.walk_init = 1'b1;
          ctrl.clear     = 1'b0;
        end else if (!stat.cmd_add && !stat.cmd_remove) begin
          ctrl.clear = 1'b1;
        end else if (!stat.search_done) begin
          ctrl.search_step = 1'b1;
        end else begin
          rem_load = stat.cmd_remove && stat.found;
        end
      end
      prcs_pkg::S_ADD:    ctrl.add_step = 1'b1;
      prcs_pkg::S_REMOVE: ctrl.rem_step = 1'b1;
      prcs_pkg::S_WALK:   ctrl.walk_step = 1'b1;
      prcs_pkg::S_PACK:   ctrl.pack_step = 1'b1;
      default: ;
    endcase
  end

endmodule

@@ sv/priority_resource_command_scheduler_core.sv @@
// ----------------------------------------------------------------------------
// priority_resource_command_scheduler_core
// Priority command queue with subsystem locking, one report per walked entry.
// ----------------------------------------------------------------------------
// channel  | handshake          | payload
// input    | start / busy       | in_cmd, in_command_id, in_priority_req, masks
// result   | out_valid (strobe) | out_result_id, flags, out_last
// config   | cfg_we             | cfg_wdata (num_subsystems)
//
// Tick: one entry per cycle through the grant unit, then a pack pass that
// moves the surviving entries down over the dropped ones; an empty queue skips
// both. Add/remove: a scan of up to 16 entries plus a shift of up to 16.
// Clear empties the queue. Reset is synchronous; the queue needs no clearing pass.
// Results cannot be stalled: each shows for one cycle.
module priority_resource_command_scheduler_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_cmd,
  input  logic [3:0]  in_command_id,
  input  logic [7:0]  in_priority_req,
  input  logic [15:0] in_requirement_mask,
  input  logic [15:0] in_can_run_mask,
  input  logic [15:0] in_finished_mask,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata,
  output logic        out_valid,
  output logic [3:0]  out_result_id,
  output logic        out_started,
  output logic        out_executed,
  output logic        out_ended,
  output logic        out_was_interrupted,
  output logic        out_dropped,
  output logic        out_last
);

  prcs_pkg::ctrl_t ctrl, ctrl_dp;
  prcs_pkg::stat_t stat;
  logic            rem_load;

  always_comb begin
    ctrl_dp = ctrl;
  end

  prcs_ctrl u_ctrl (
    .clk, .rst_n, .start, .busy, .stat, .ctrl, .rem_load
  );

  prcs_datapath u_dp (
    .clk, .rst_n, .ctrl(ctrl_dp), .stat, .rem_load,
    .in_cmd, .in_command_id, .in_priority_req, .in_requirement_mask,
    .in_can_run_mask, .in_finished_mask, .cfg_we, .cfg_wdata,
    .out_valid, .out_result_id, .out_started, .out_executed, .out_ended,
    .out_was_interrupted, .out_dropped, .out_last
  );

endmodule

@@ sv/prcs_checker.sv @@
// ----------------------------------------------------------------------------
// prcs_checker
// Port-level checks on the scheduler's result strobe and flags.
// ----------------------------------------------------------------------------
module prcs_checker (
  input logic clk,
  input logic rst_n,
  input logic busy,
  input logic out_valid,
  input logic out_started,
  input logic out_executed,
  input logic out_ended,
  input logic out_was_interrupted,
  input logic out_last
);

  a_no_report_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy)) else $error("report without work");

  a_start_exec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_started |-> out_executed) else $error("start without exec");

  a_end_exec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ended |-> out_executed) else $error("end without exec");

  a_intr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_was_interrupted |-> !out_executed) else $error("intr and exec");

  a_last_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |=> !out_valid) else $error("report after last");

endmodule

bind priority_resource_command_scheduler_core prcs_checker u_prcs_checker (
  .clk, .rst_n, .busy, .out_valid, .out_started, .out_executed,
  .out_ended, .out_was_interrupted, .out_last
);
